### rtl/dq_pkg.sv
// Shared opcodes, status codes and controller/datapath interface types for the deque.
`timescale 1ns / 1ps
package dq_pkg;

  localparam int OpW   = 3;
  localparam int DataW = 32;
  localparam int StW   = 2;
  localparam int PosW  = 8;

  localparam logic [OpW-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OpW-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OpW-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OpW-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OpW-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OpW-1:0] OP_PEEK_BACK  = 3'd5;
  localparam logic [OpW-1:0] OP_READ_INDEX = 3'd6;

  localparam logic [StW-1:0] ST_OK        = 2'd0;
  localparam logic [StW-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [StW-1:0] ST_RANGE     = 2'd2;
  localparam logic [StW-1:0] ST_OVERFLOW  = 2'd3;

  localparam logic [1:0] SEL_FRONT = 2'd0;
  localparam logic [1:0] SEL_BACK  = 2'd1;
  localparam logic [1:0] SEL_INDEX = 2'd2;

  typedef struct packed {
    logic           wr_front;
    logic           wr_back;
    logic           del_front;
    logic           del_back;
    logic           rd_en;
    logic [1:0]     rd_sel;
    logic           res_load;
    logic           res_err;
    logic [StW-1:0] res_status;
    logic           mem_load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic index_ok;
    logic out_busy;
  } stat_t;

endpackage

### rtl/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/dq_ctrl.sv
// Deque controller: accepts requests, decodes opcodes, sequences memory reads.
`timescale 1ns / 1ps
module dq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [dq_pkg::OpW-1:0] opcode,
  input  dq_pkg::stat_t         stat,
  output dq_pkg::cmd_t          cmd
);
  import dq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign s_tready = (state == ST_IDLE) && !stat.out_busy;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.res_load = 1'b1;
          case (opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (stat.full) begin
                cmd.res_err    = 1'b1;
                cmd.res_status = ST_OVERFLOW;
              end else begin
                cmd.wr_front = (opcode == OP_PUSH_FRONT);
                cmd.wr_back  = (opcode == OP_PUSH_BACK);
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (stat.empty) begin
                cmd.res_err    = 1'b1;
                cmd.res_status = ST_UNDERFLOW;
              end else begin
                cmd.del_front = (opcode == OP_POP_FRONT);
                cmd.del_back  = (opcode == OP_POP_BACK);
              end
            end
            OP_PEEK_FRONT, OP_PEEK_BACK: begin
              if (stat.empty) begin
                cmd.res_err    = 1'b1;
                cmd.res_status = ST_UNDERFLOW;
              end else begin
                // result comes from memory next cycle
                cmd.res_load = 1'b0;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = (opcode == OP_PEEK_FRONT) ? SEL_FRONT : SEL_BACK;
                state_next   = ST_READ;
              end
            end
            OP_READ_INDEX: begin
              if (!stat.index_ok) begin
                cmd.res_err    = 1'b1;
                cmd.res_status = ST_RANGE;
              end else begin
                cmd.res_load = 1'b0;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = SEL_INDEX;
                state_next   = ST_READ;
              end
            end
            default: begin
              cmd.res_status = ST_OK;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.mem_load = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_read_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (state == ST_IDLE))
    else $error("read state lasted more than one cycle");

  a_no_accept_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !s_tready)
    else $error("request accepted while a memory read is pending");

endmodule

### rtl/dq_dp.sv
// Deque datapath: head pointer, count, ring memory and result register.
`timescale 1ns / 1ps
module dq_dp #(
  parameter int DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dq_pkg::cmd_t              cmd,
  output dq_pkg::stat_t             stat,
  input  logic [dq_pkg::DataW-1:0]  push_value,
  input  logic [dq_pkg::PosW-1:0]   position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dq_pkg::DataW-1:0]  read_data,
  output logic [dq_pkg::StW-1:0]    status
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int OW = (CW > PosW) ? CW : PosW;
  localparam int SW = OW + 1;

  logic [AW-1:0]    head;
  logic [CW-1:0]    count;
  logic [AW-1:0]    head_dec;
  logic [AW-1:0]    head_inc;
  logic [OW-1:0]    rd_off;
  logic [SW-1:0]    rd_sum;
  logic [SW-1:0]    wr_sum;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    back_addr;
  logic [AW-1:0]    wr_addr;
  logic [DataW-1:0] ram_rdata;

  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CW'(DEPTH));
  assign stat.index_ok = (OW'(position) < OW'(count));
  assign stat.out_busy = out_valid && !out_ready;

  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;

  // offsets are below DEPTH, so one conditional subtract wraps the sum
  always_comb begin
    case (cmd.rd_sel)
      SEL_FRONT: rd_off = '0;
      SEL_BACK:  rd_off = OW'(count) - 1'b1;
      SEL_INDEX: rd_off = OW'(position);
      default:   rd_off = '0;
    endcase
  end

  assign rd_sum  = SW'(head) + SW'(rd_off);
  assign rd_addr = (rd_sum >= SW'(DEPTH)) ? AW'(rd_sum - SW'(DEPTH)) : AW'(rd_sum);

  assign wr_sum    = SW'(head) + SW'(count);
  assign back_addr = (wr_sum >= SW'(DEPTH)) ? AW'(wr_sum - SW'(DEPTH)) : AW'(wr_sum);
  assign wr_addr   = cmd.wr_front ? head_dec : back_addr;

  dq_ram #(
    .WIDTH (DataW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_front || cmd.wr_back),
    .waddr (wr_addr),
    .wdata (push_value),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (cmd.wr_front) begin
        head <= head_dec;
      end else if (cmd.del_front) begin
        head <= head_inc;
      end
      if (cmd.wr_front || cmd.wr_back) begin
        count <= count + 1'b1;
      end else if (cmd.del_front || cmd.del_back) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load || cmd.mem_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      read_data <= cmd.res_err ? '1 : '0;
      status    <= cmd.res_status;
    end else if (cmd.mem_load) begin
      read_data <= ram_rdata;
      status    <= ST_OK;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count exceeds ring depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    SW'(head) < SW'(DEPTH))
    else $error("head pointer outside ring");

  a_mem_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_load |-> !out_valid)
    else $error("memory result would overwrite a pending result");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_front || cmd.wr_back) |=> (count == CW'($past(count) + 1'b1)))
    else $error("push did not advance count");

endmodule

### rtl/double_ended_queue_core.sv
// Top level of the double-ended queue: stream ports, controller and datapath.
`timescale 1ns / 1ps
// Deque of signed 32-bit words in a ring of DEPTH entries. Each request on the
// slave stream carries an opcode and gives exactly one result on the master
// stream. Push, pop, error and unused-opcode requests load the result register directly;
// peek front, peek back and read at index go through the registered read port of the
// ring memory and hold off the next request while that read is pending. A new request
// is taken when no memory read is pending and the result register is free or
// being drained in the same cycle. A push into a full ring is dropped with
// status overflow; errors return data all ones.
module double_ended_queue_core #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // opcode[2:0], push_value[34:3], position[42:35], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // read_data[31:0], status[33:32], zero pad
);
  import dq_pkg::*;

  cmd_t             cmd;
  stat_t            stat;
  logic [OpW-1:0]   opcode;
  logic [DataW-1:0] push_value;
  logic [PosW-1:0]  position;
  logic [DataW-1:0] read_data;
  logic [StW-1:0]   status;

  assign opcode     = s_tdata[2:0];
  assign push_value = s_tdata[34:3];
  assign position   = s_tdata[42:35];
  assign m_tdata    = {6'd0, status, read_data};

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (opcode),
    .stat     (stat),
    .cmd      (cmd)
  );

  dq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .push_value (push_value),
    .position   (position),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .read_data  (read_data),
    .status     (status)
  );

endmodule

### sim/deque_checker.sv
// Checker for the deque core: tracks accepted requests, predicts each result and compares.
`timescale 1ns / 1ps
module deque_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,     // opcode[2:0], push_value[34:3], position[42:35], zero pad
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,     // read_data[31:0], status[33:32], zero pad
  output int          pending,
  output int          mismatches
);
  import dq_pkg::*;

  localparam int RingSize   = 256;
  localparam int ReportMax  = 10;
  localparam int AwaitDepth = 1024;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic [StW-1:0]   status;
  } deque_result_t;

  // Shadow copy of the ring, its front slot and its fill level
  logic [DataW-1:0] ring_copy [RingSize];
  logic [7:0]       front_slot;
  logic [8:0]       occupancy;
  // Expected results in order of acceptance
  deque_result_t    awaited [AwaitDepth];
  int               wr_ptr;
  int               rd_ptr;
  int               bad_count;

  function automatic deque_result_t apply_request(logic [OpW-1:0] op, logic [DataW-1:0] word,
                                                  logic [PosW-1:0] offset);
    deque_result_t r;
    r.data   = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (int'(occupancy) == RingSize) begin
          r.data   = '1;
          r.status = ST_OVERFLOW;
        end else if (op == OP_PUSH_FRONT) begin
          front_slot            = front_slot - 8'd1;
          ring_copy[front_slot] = word;
          occupancy++;
        end else begin
          ring_copy[8'(front_slot + occupancy)] = word;
          occupancy++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (occupancy == 9'd0) begin
          r.data   = '1;
          r.status = ST_UNDERFLOW;
        end else if (op == OP_POP_FRONT) begin
          front_slot = front_slot + 8'd1;
          occupancy--;
        end else if (op == OP_POP_BACK) begin
          occupancy--;
        end else if (op == OP_PEEK_FRONT) begin
          r.data = ring_copy[front_slot];
        end else begin
          r.data = ring_copy[8'(front_slot + occupancy - 9'd1)];
        end
      end
      OP_READ_INDEX: begin
        if ({1'b0, offset} >= occupancy) begin
          r.data   = '1;
          r.status = ST_RANGE;
        end else begin
          r.data = ring_copy[8'(front_slot + offset)];
        end
      end
      default: ;  // unused opcode: no state change, zero result
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (rst) begin
      front_slot = '0;
      occupancy  = '0;
      bad_count  = 0;
      wr_ptr     = 0;
      rd_ptr     = 0;
    end else begin
      // retire the result first: it never belongs to a request taken at this edge
      if (m_tvalid && m_tready) begin
        got.data   = m_tdata[31:0];
        got.status = m_tdata[33:32];
        if (wr_ptr == rd_ptr) begin
          if (bad_count < ReportMax)
            $display("deque: unexpected result data %h status %0d", got.data, got.status);
          bad_count++;
        end else begin
          want = awaited[rd_ptr[9:0]];
          rd_ptr++;
          if (got.data !== want.data || got.status !== want.status) begin
            if (bad_count < ReportMax)
              $display("deque: mismatch, expected data %h status %0d, got data %h status %0d",
                       want.data, want.status, got.data, got.status);
            bad_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        awaited[wr_ptr[9:0]] = apply_request(s_tdata[2:0], s_tdata[34:3], s_tdata[42:35]);
        wr_ptr++;
      end
    end
    pending    <= wr_ptr - rd_ptr;
    mismatches <= bad_count;
  end

endmodule

### sim/testbench.sv
// Top of the deque testbench: clock, reset, request and result stream drivers, verdict.
`timescale 1ns / 1ps
module testbench;
  import dq_pkg::*;

  localparam logic [OpW-1:0] OP_UNUSED = 3'd7;

  localparam int RingSize    = 256;
  localparam int RandomItems = 930;
  localparam int HoldAfter   = 300;
  localparam int HoldCycles  = 400;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 10;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [47:0] s_tdata  = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [39:0] m_tdata;
  int          pending;
  int          mismatches;

  // Fill level as seen by the request generator, used only to steer stimulus
  int level = 0;
  int sent  = 0;

  always #4 clk = ~clk;

  double_ended_queue_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  deque_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .pending    (pending),
    .mismatches (mismatches)
  );

  task automatic send_request(input logic [OpW-1:0] op, input logic [DataW-1:0] word,
                              input logic [PosW-1:0] offset);
    int gap;
    gap = ((sent / 90) % 4 == 2) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, offset, word, op};
    do @(posedge clk); while (!s_tready);
    sent++;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (level < RingSize) level++;
      OP_POP_FRONT, OP_POP_BACK:   if (level > 0) level--;
      default: ;
    endcase
  endtask

  initial begin : request_source
    logic [OpW-1:0]   op;
    logic [DataW-1:0] word;
    logic [PosW-1:0]  offset;
    int               target;
    int               seg_left;
    int               seg_no;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty ring: every read-type request underflows or is out of range
    send_request(OP_PEEK_FRONT, 32'h1234_5678, 8'd0);
    send_request(OP_PEEK_BACK, 32'h0, 8'd0);
    send_request(OP_POP_FRONT, 32'h0, 8'd0);
    send_request(OP_POP_BACK, 32'h0, 8'd0);
    send_request(OP_READ_INDEX, 32'h0, 8'd0);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF);
    // extremes of the word, pushing at both ends so the front wraps below slot zero
    send_request(OP_PUSH_BACK, 32'h7FFF_FFFF, 8'h00);
    send_request(OP_PUSH_FRONT, 32'h8000_0000, 8'hFF);
    send_request(OP_PUSH_BACK, 32'h0000_0000, 8'h00);
    send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF, 8'h00);
    send_request(OP_PUSH_BACK, 32'h5A5A_A5A5, 8'h00);
    send_request(OP_PEEK_FRONT, 32'h0, 8'h00);
    send_request(OP_PEEK_BACK, 32'h0, 8'h00);
    send_request(OP_READ_INDEX, 32'h0, 8'd0);
    send_request(OP_READ_INDEX, 32'h0, 8'd1);
    send_request(OP_READ_INDEX, 32'h0, 8'd4);
    send_request(OP_READ_INDEX, 32'h0, 8'd5);
    send_request(OP_READ_INDEX, 32'h0, 8'd255);
    send_request(OP_POP_FRONT, 32'h0, 8'd0);
    send_request(OP_POP_BACK, 32'h0, 8'd0);
    send_request(OP_PEEK_FRONT, 32'h0, 8'd0);
    send_request(OP_UNUSED, 32'hA5A5_5A5A, 8'h55);
    send_request(OP_POP_FRONT, 32'h0, 8'd0);
    send_request(OP_POP_BACK, 32'h0, 8'd0);
    send_request(OP_POP_FRONT, 32'h0, 8'd0);
    send_request(OP_POP_BACK, 32'h0, 8'd0);

    // steer the level toward a target per segment: first full, then empty, then anywhere
    seg_no   = 0;
    target   = RingSize;
    seg_left = 420;
    for (int n = 0; n < RandomItems; n++) begin
      if (seg_left == 0) begin
        seg_no++;
        if (seg_no == 1) begin
          target = 0;
        end else begin
          case ($urandom_range(0, 3))
            0:       target = RingSize;
            1:       target = 0;
            default: target = $urandom_range(0, RingSize);
          endcase
        end
        seg_left = (seg_no == 1) ? 380 : $urandom_range(60, 300);
      end
      seg_left--;
      if (level != target && $urandom_range(0, 9) < 8) begin
        if (level < target) op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else                op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end else begin
        op = 3'($urandom_range(0, 7));
      end
      case ($urandom_range(0, 7))
        0:       word = 32'h8000_0000;
        1:       word = 32'h7FFF_FFFF;
        2:       word = 32'h0000_0000;
        3:       word = 32'hFFFF_FFFF;
        default: word = $urandom();
      endcase
      if (op == OP_READ_INDEX && $urandom_range(0, 3) != 0)
        offset = 8'($urandom_range(0, (level > 255) ? 255 : level));
      else
        offset = 8'($urandom_range(0, 255));
      send_request(op, word, offset);
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else                 $display("tb: failure");
    $finish;
  end

  // Result side: random gaps per result, runs with no gaps, and one long hold
  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    wait (rst == 1'b0);
    forever begin
      if (taken == HoldAfter)            gap = HoldCycles;
      else if ((taken / 70) % 4 == 1)    gap = 0;
      else                               gap = $urandom_range(0, 19);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else                                                  idle++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
